[sv/assert_macros.svh]
// assertion helper macros used by the rtl file afr_deframer
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

[sv/afr_pkg.sv]
// types, constants and the crc byte update for the ack frame receiver
// no dependencies
package afr_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;
    localparam logic [7:0] KIND_ACK    = 8'h22;
    localparam logic [7:0] KIND_NACK   = 8'h23;
    localparam logic [7:0] SEQ_BYTES   = 8'd2;
    localparam logic [7:0] CODE_BYTES  = 8'd4;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    localparam logic [2:0] ST_ACK_MATCH  = 3'd0;
    localparam logic [2:0] ST_NACK_MATCH = 3'd1;
    localparam logic [2:0] ST_OTHER_SEQ  = 3'd2;
    localparam logic [2:0] ST_OTHER      = 3'd3;
    localparam logic [2:0] ST_CRC_ERR    = 3'd4;
    localparam logic [2:0] ST_ZERO_LEN   = 3'd5;

    typedef enum logic [6:0] {
        PH_HUNT1 = 7'b0000001,
        PH_HUNT2 = 7'b0000010,
        PH_LEN   = 7'b0000100,
        PH_KIND  = 7'b0001000,
        PH_BODY  = 7'b0010000,
        PH_CRCLO = 7'b0100000,
        PH_CRCHI = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic       vld;
        logic [7:0] data;
    } in_item_t;

    // crc-16/modbus, reflected, one byte
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

[sv/afr_in_reg.sv]
// input register for received bytes, frees itself when the deframer takes the byte
// depends on afr_pkg
module afr_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        rx_byte,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              take,
    output afr_pkg::in_item_t item
);
    import afr_pkg::*;

    logic       vld_reg, vld_next;
    logic [7:0] data_reg;

    assign in_ready = !vld_reg || take;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_valid && in_ready)
            vld_next = 1'b1;
        else if (take)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= rx_byte;
    end

    assign item.vld  = vld_reg;
    assign item.data = data_reg;

endmodule

[sv/afr_deframer.sv]
// frame state machine, crc accumulator and result register
// depends on afr_pkg and assert_macros.svh
`include "assert_macros.svh"
module afr_deframer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              expected_seq_we,
    input  logic [15:0]       expected_seq_wdata,
    input  afr_pkg::in_item_t item,
    output logic              take,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        status,
    output logic [7:0]        frame_kind,
    output logic [15:0]       frame_seq,
    output logic [15:0]       nack_code,
    output logic              code_valid,
    output logic [7:0]        body_len
);
    import afr_pkg::*;

    logic [15:0] expected_seq_reg;
    phase_t      phase_reg, phase_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  kind_reg, kind_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] seq_reg, seq_next;
    logic [15:0] code_reg, code_next;
    logic [7:0]  crc_low_reg, crc_low_next;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  status_reg, status_next;
    logic [7:0]  kind_out_reg, kind_out_next;
    logic [15:0] seq_out_reg, seq_out_next;
    logic [15:0] code_out_reg, code_out_next;
    logic        cv_out_reg, cv_out_next;
    logic [7:0]  blen_out_reg, blen_out_next;

    logic        emit;
    logic [2:0]  emit_status;
    logic [7:0]  emit_kind;
    logic [7:0]  blen;
    logic [7:0]  b;
    logic [15:0] crc_upd;
    logic [7:0]  count_inc;

    // one byte per cycle unless a finished result is stuck at the output
    assign take      = item.vld && (!out_valid_reg || out_ready);
    assign b         = item.data;
    assign crc_upd   = crc_feed(crc_reg, b);
    assign count_inc = count_reg + 8'd1;
    assign blen      = (len_reg == 8'd0) ? 8'd0 : len_reg - 8'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        len_next     = len_reg;
        kind_next    = kind_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        seq_next     = seq_reg;
        code_next    = code_reg;
        crc_low_next = crc_low_reg;
        emit         = 1'b0;
        emit_status  = ST_OTHER;
        emit_kind    = kind_reg;
        if (take)
        begin
            case (phase_reg)
                PH_HUNT1:
                begin
                    if (b == SYNC_FIRST)
                        phase_next = PH_HUNT2;
                end
                PH_HUNT2:
                begin
                    if (b == SYNC_SECOND)
                    begin
                        phase_next = PH_LEN;
                        crc_next   = CRC_INIT;
                        seq_next   = 16'h0000;
                        code_next  = 16'h0000;
                        count_next = 8'd0;
                    end
                    else if (b != SYNC_FIRST)
                        phase_next = PH_HUNT1;
                end
                PH_LEN:
                begin
                    len_next   = b;
                    crc_next   = crc_upd;
                    phase_next = PH_KIND;
                end
                PH_KIND:
                begin
                    kind_next = b;
                    crc_next  = crc_upd;
                    if (len_reg == 8'd0)
                    begin
                        phase_next  = PH_HUNT1;
                        emit        = 1'b1;
                        emit_status = ST_ZERO_LEN;
                        emit_kind   = b;
                    end
                    else if (len_reg == 8'd1)
                        phase_next = PH_CRCLO;
                    else
                        phase_next = PH_BODY;
                end
                PH_BODY:
                begin
                    crc_next = crc_upd;
                    case (count_reg)
                        8'd0:    seq_next  = {seq_reg[15:8], b};
                        8'd1:    seq_next  = {b, seq_reg[7:0]};
                        8'd2:    code_next = {code_reg[15:8], b};
                        8'd3:    code_next = {b, code_reg[7:0]};
                        default: ;
                    endcase
                    count_next = count_inc;
                    if (count_inc >= len_reg - 8'd1)
                        phase_next = PH_CRCLO;
                end
                PH_CRCLO:
                begin
                    crc_low_next = b;
                    phase_next   = PH_CRCHI;
                end
                PH_CRCHI:
                begin
                    phase_next = PH_HUNT1;
                    emit       = 1'b1;
                    if ({b, crc_low_reg} != crc_reg)
                        emit_status = ST_CRC_ERR;
                    else if ((kind_reg == KIND_ACK || kind_reg == KIND_NACK)
                             && blen >= SEQ_BYTES)
                    begin
                        if (seq_reg != expected_seq_reg)
                            emit_status = ST_OTHER_SEQ;
                        else if (kind_reg == KIND_ACK)
                            emit_status = ST_ACK_MATCH;
                        else
                            emit_status = ST_NACK_MATCH;
                    end
                    else
                        emit_status = ST_OTHER;
                end
                default:
                    phase_next = PH_HUNT1;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        kind_out_next  = kind_out_reg;
        seq_out_next   = seq_out_reg;
        code_out_next  = code_out_reg;
        cv_out_next    = cv_out_reg;
        blen_out_next  = blen_out_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (emit)
        begin
            out_valid_next = 1'b1;
            status_next    = emit_status;
            kind_out_next  = emit_kind;
            seq_out_next   = (blen >= SEQ_BYTES) ? seq_reg : 16'h0000;
            code_out_next  = (blen >= CODE_BYTES) ? code_reg : 16'h0000;
            cv_out_next    = (blen >= CODE_BYTES);
            blen_out_next  = blen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_seq_reg <= 16'h0000;
            phase_reg        <= PH_HUNT1;
            len_reg          <= 8'd0;
            kind_reg         <= 8'd0;
            count_reg        <= 8'd0;
            crc_reg          <= CRC_INIT;
            seq_reg          <= 16'h0000;
            code_reg         <= 16'h0000;
            crc_low_reg      <= 8'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (expected_seq_we)
                expected_seq_reg <= expected_seq_wdata;
            phase_reg     <= phase_next;
            len_reg       <= len_next;
            kind_reg      <= kind_next;
            count_reg     <= count_next;
            crc_reg       <= crc_next;
            seq_reg       <= seq_next;
            code_reg      <= code_next;
            crc_low_reg   <= crc_low_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        kind_out_reg <= kind_out_next;
        seq_out_reg  <= seq_out_next;
        code_out_reg <= code_out_next;
        cv_out_reg   <= cv_out_next;
        blen_out_reg <= blen_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign frame_kind = kind_out_reg;
    assign frame_seq  = seq_out_reg;
    assign nack_code  = code_out_reg;
    assign code_valid = cv_out_reg;
    assign body_len   = blen_out_reg;

    `ASSERT_NEVER(a_no_overwrite, clk, rst_n, take && out_valid_reg && !out_ready, "byte taken while result stalled")
    `ASSERT_CLKD(a_emit_phase, clk, rst_n, emit |-> (phase_reg == PH_KIND || phase_reg == PH_CRCHI), "result from wrong phase")
    `ASSERT_CLKD(a_zero_len, clk, rst_n, (out_valid_reg && status_reg == ST_ZERO_LEN) |-> (blen_out_reg == 8'd0 && !cv_out_reg && seq_out_reg == 16'h0000), "zero length result fields")
    `ASSERT_CLKD(a_code_valid, clk, rst_n, (out_valid_reg && cv_out_reg) |-> (blen_out_reg >= CODE_BYTES), "code valid on short payload")

endmodule

[sv/ack_frame_receiver.sv]
// Ack frame receiver: takes one received byte per transaction and hunts for the sync pair
// AA 55, then reads a length byte, a type byte, length-1 payload bytes and a CRC-16/MODBUS
// (low byte first) over length, type and payload. After the last CRC byte, or after the type
// byte of a zero-length frame, one result transaction gives the status, type, sequence and
// nack code. A byte is accepted every cycle; it waits in an input register until the
// deframer takes it, and the result is registered at the deframer output. The one-byte
// crc update in the deframer is the longest path per byte. Input accept stalls only while a
// finished result waits at the output. The user must write expected_seq through the ports
// expected_seq_we / expected_seq_wdata only while no frame is in flight (not enforced).
// depends on afr_pkg, afr_in_reg, afr_deframer
module ack_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        expected_seq_we,
    input  logic [15:0] expected_seq_wdata,
    input  logic [7:0]  rx_byte,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [7:0]  frame_kind,
    output logic [15:0] frame_seq,
    output logic [15:0] nack_code,
    output logic        code_valid,
    output logic [7:0]  body_len
);
    import afr_pkg::*;

    in_item_t item;
    logic     take;

    afr_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_byte  (rx_byte),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .take     (take),
        .item     (item)
    );

    afr_deframer u_deframer (
        .clk                (clk),
        .rst_n              (rst_n),
        .expected_seq_we    (expected_seq_we),
        .expected_seq_wdata (expected_seq_wdata),
        .item               (item),
        .take               (take),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .frame_kind         (frame_kind),
        .frame_seq          (frame_seq),
        .nack_code          (nack_code),
        .code_valid         (code_valid),
        .body_len           (body_len)
    );

endmodule
